// File: hdl/first_fit_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// first_fit_block_allocator_defines
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// property holds on every clock edge outside reset
`define FFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NO_SPACE  = 2'd3;

    localparam logic CFG_REGION_BASE  = 1'b0;
    localparam logic CFG_REGION_BYTES = 1'b1;

    // header entry held at one granule slot
    typedef struct packed {
        logic        used;
        logic [20:0] next;
        logic [16:0] size;
    } hdr_t;

    // memory request from the sequencer
    typedef struct packed {
        logic  we;
        hdr_t  wdata;
    } mreq_t;

endpackage

// File: hdl/ffba_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffba_hdr_mem
// Header store: one entry per granule, synchronous read into a registered rdata.
// ----------------------------------------------------------------------------
module ffba_hdr_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic             clk,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    input  ffba_pkg::mreq_t  req,
    input  logic [AW-1:0]    waddr,
    output ffba_pkg::hdr_t   rdata
);
    import ffba_pkg::*;

    hdr_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[waddr] <= req.wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over one region, chain of headers kept in block RAM.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// s_axis   in   s_axis_tvalid/tready   tdata: operation, length, offset
// m_axis   out  m_axis_tvalid/tready   tdata: status, alloc_offset
// cfg      in   cfg_we                 cfg_index, cfg_wdata
// One item at a time: the accept, a header RAM read and an evaluate per
// chain hop, a split state for a split, then a final done state. A release
// then merges: a RAM read and an evaluate per free neighbour, plus a second
// walk from the head to find the predecessor. Reset and config writes made
// while idle rebuild the chain with one header write if a header fits.
// One output register; a next item is taken in idle once the result leaves.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
    parameter int MAX_REGION_BYTES = 65536,
    parameter int HEADER_BYTES     = 24,
    parameter int GRANULE_BYTES    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // operation[1:0], length[18:2], offset[39:19]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[1:0], alloc_offset[22:2], zero pad
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_wdata
);
    import ffba_pkg::*;

    localparam int HSPAN = ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES)
                           * GRANULE_BYTES;
    localparam int DEPTH = (MAX_REGION_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GSH   = $clog2(GRANULE_BYTES);
    localparam logic [22:0] HSPAN_W = 23'(HSPAN);
    localparam logic [22:0] GRAN_W  = 23'(GRANULE_BYTES);
    localparam logic [22:0] GMASK   = 23'(GRANULE_BYTES - 1);
    localparam logic [17:0] MAXR    = 18'(MAX_REGION_BYTES > 131071 ? 131071
                                                                    : MAX_REGION_BYTES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_EVAL  = 9'b000000100,
        S_SPLIT = 9'b000001000,
        S_MN_RD = 9'b000010000,
        S_MN_EV = 9'b000100000,
        S_MP_RD = 9'b001000000,
        S_MP_EV = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [19:0] base_reg;
    logic [16:0] bytes_reg;
    logic        hv_reg;
    logic        init_reg;
    logic [1:0]  op_reg;
    logic [22:0] need_reg;
    logic [16:0] len_reg;
    logic [22:0] target_reg;
    logic [20:0] cur_reg, cur_next;
    logic [20:0] rel_reg, rel_next;     // released block / merge base
    logic        prevpass_reg, prevpass_next;
    hdr_t        hc_reg, hc_next;       // header of cur_reg
    logic        out_v_reg;
    logic [1:0]  ost_reg;
    logic [20:0] opay_reg;
    logic        res_v, fin;
    logic [1:0]  res_st;
    logic [20:0] res_pay;

    logic        re;
    logic [AW-1:0] raddr, waddr;
    mreq_t       req;
    hdr_t        rdata;

    ffba_hdr_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .re(re), .raddr(raddr), .req(req), .waddr(waddr), .rdata(rdata)
    );

    function automatic logic [AW-1:0] slot_of(input logic [22:0] rel);
        logic [22:0] i;
        begin
            i = rel >> GSH;
            slot_of = (i < 23'(DEPTH)) ? i[AW-1:0] : '0;
        end
    endfunction

    logic        cfg_hit;
    logic [16:0] eff;
    logic [19:0] nbase;
    logic [16:0] nbytes;
    always_comb
    begin
        nbase  = (cfg_we && cfg_index == CFG_REGION_BASE) ? cfg_wdata : base_reg;
        nbytes = (cfg_we && cfg_index == CFG_REGION_BYTES) ? cfg_wdata[16:0] : bytes_reg;
        eff    = ({1'b0, nbytes} > MAXR) ? MAXR[16:0] : nbytes;
        cfg_hit = cfg_we;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && init_reg && !cfg_we &&
                           (!out_v_reg || m_axis_tready);

    logic        acc;
    logic [1:0]  in_op;
    logic [16:0] in_len;
    logic [20:0] in_off;
    assign acc    = s_axis_tvalid && s_axis_tready;
    assign in_op  = s_axis_tdata[1:0];
    assign in_len = s_axis_tdata[18:2];
    assign in_off = s_axis_tdata[39:19];

    logic [22:0] cur_w, nx_w, end_w, rest_w, nrel_w;
    always_comb
    begin
        cur_w  = {2'b0, cur_reg};
        nx_w   = {2'b0, rdata.next};
        end_w  = cur_w + HSPAN_W + {6'b0, rdata.size};
        rest_w = {6'b0, rdata.size} - need_reg;
        nrel_w = cur_w + HSPAN_W + need_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        rel_next      = rel_reg;
        prevpass_next = prevpass_reg;
        hc_next       = hc_reg;
        re            = 1'b0;
        raddr         = slot_of(cur_w);
        req           = '0;
        waddr         = slot_of(cur_w);
        res_v         = 1'b0;
        fin           = 1'b0;
        res_st        = ST_OK;
        res_pay       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_hit || !init_reg)
                begin
                    // rebuild: single free block at relative zero
                    req.we         = (eff >= 17'(HSPAN));
                    req.wdata.used = 1'b0;
                    req.wdata.next = '0;
                    req.wdata.size = eff - 17'(HSPAN);
                    waddr          = '0;
                end
                else if (acc)
                begin
                    cur_next      = '0;
                    prevpass_next = 1'b0;
                    state_next    = S_DONE;
                    res_v         = 1'b1;
                    if (in_op == OP_ALLOC)
                    begin
                        if (!hv_reg) res_st = ST_NO_SPACE;
                        else state_next = S_RD;
                    end
                    else if (in_op == OP_RELEASE || in_op == OP_CHECK)
                    begin
                        if (in_op == OP_CHECK && !hv_reg) res_st = ST_NO_SPACE;
                        else if (in_off < 21'(HSPAN)) res_st = ST_INVALID;
                        else if (!hv_reg || {2'b0, in_off} < {3'b0, base_reg} + HSPAN_W)
                            res_st = ST_NOT_FOUND;
                        else state_next = S_RD;
                    end
                    else
                    begin
                        res_st = ST_INVALID;
                    end
                    if (state_next == S_RD) res_v = 1'b0;
                end
            end
            S_RD:
            begin
                re         = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                hc_next = rdata;
                if (op_reg == OP_ALLOC)
                begin
                    if (!rdata.used && {6'b0, rdata.size} >= need_reg)
                    begin
                        res_v   = 1'b1;
                        res_pay = 21'({3'b0, base_reg} + cur_w + HSPAN_W);
                        req.we  = 1'b1;
                        req.wdata.used = 1'b1;
                        req.wdata.next = rdata.next;
                        req.wdata.size = rdata.size;
                        state_next     = S_DONE;
                        if (rest_w >= HSPAN_W + GRAN_W)
                        begin
                            req.wdata.next = nrel_w[20:0];
                            req.wdata.size = need_reg[16:0];
                            rel_next       = nrel_w[20:0];
                            state_next     = S_SPLIT;
                        end
                    end
                    else if (rdata.next == '0 || nx_w <= cur_w)
                    begin
                        res_v = 1'b1; res_st = ST_NO_SPACE; state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next = rdata.next; state_next = S_RD;
                    end
                end
                else if (cur_w == target_reg)
                begin
                    state_next = S_DONE;
                    res_v      = 1'b1;
                    if (!rdata.used) res_st = ST_NOT_FOUND;
                    else if (op_reg == OP_CHECK && len_reg > rdata.size) res_st = ST_INVALID;
                    else if (op_reg == OP_RELEASE)
                    begin
                        req.we         = 1'b1;
                        req.wdata      = rdata;
                        req.wdata.used = 1'b0;
                        hc_next.used   = 1'b0;
                        rel_next       = cur_reg;
                        state_next     = S_MN_RD;
                    end
                end
                else if (cur_w > target_reg || rdata.next == '0 || nx_w <= cur_w)
                begin
                    res_v = 1'b1; res_st = ST_NOT_FOUND; state_next = S_DONE;
                end
                else
                begin
                    cur_next = rdata.next; state_next = S_RD;
                end
            end
            S_SPLIT:
            begin
                // remainder header; hc_reg holds the original block
                req.we         = 1'b1;
                req.wdata.used = 1'b0;
                req.wdata.next = hc_reg.next;
                req.wdata.size = 17'({6'b0, hc_reg.size} - need_reg - HSPAN_W);
                waddr          = slot_of({2'b0, rel_reg});
                state_next     = S_DONE;
            end
            S_MN_RD:
            begin
                // hc_reg is the free block at cur_reg
                raddr = slot_of({2'b0, hc_reg.next});
                re    = 1'b1;
                if (hc_reg.next == '0 ||
                    {2'b0, hc_reg.next} != cur_w + HSPAN_W + {6'b0, hc_reg.size})
                begin
                    re = 1'b0;
                    state_next = prevpass_reg ? S_DONE : S_MP_RD;
                    cur_next   = '0;
                    prevpass_next = 1'b1;
                end
                else
                begin
                    state_next = S_MN_EV;
                end
            end
            S_MN_EV:
            begin
                state_next    = prevpass_reg ? S_DONE : S_MP_RD;
                prevpass_next = 1'b1;
                cur_next      = '0;
                if (!rdata.used)
                begin
                    req.we         = 1'b1;
                    req.wdata.used = 1'b0;
                    req.wdata.next = rdata.next;
                    req.wdata.size = 17'({6'b0, hc_reg.size} + HSPAN_W + {6'b0, rdata.size});
                end
            end
            S_MP_RD:
            begin
                re         = 1'b1;
                state_next = S_MP_EV;
            end
            S_MP_EV:
            begin
                hc_next = rdata;
                if (rdata.next == rel_reg)
                begin
                    if (!rdata.used && end_w == {2'b0, rel_reg}) state_next = S_MN_RD;
                    else state_next = S_DONE;
                end
                else if (rdata.next == '0 || nx_w <= cur_w)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next = rdata.next; state_next = S_MP_RD;
                end
            end
            S_DONE:
            begin
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            base_reg     <= '0;
            bytes_reg    <= 17'd65536;
            hv_reg       <= 1'b1;
            out_v_reg    <= 1'b0;
            prevpass_reg <= 1'b0;
            cur_reg      <= '0;
            rel_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            rel_reg      <= rel_next;
            prevpass_reg <= prevpass_next;
            if (cfg_hit)
            begin
                base_reg  <= nbase;
                bytes_reg <= nbytes;
                hv_reg    <= (eff >= 17'(HSPAN));
            end
            if (res_v)
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
        end
    end

    // rst_n has no path into the RAM, so the reset-time rebuild is done
    // via an init flag: the first idle cycle after reset writes the header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) init_reg <= 1'b0;
        else        init_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        hc_reg <= hc_next;
        if (res_v)
        begin
            ost_reg  <= res_st;
            opay_reg <= (res_st == ST_OK && op_reg == OP_ALLOC && state_reg != S_IDLE)
                        ? res_pay : '0;
        end
        if (acc)
        begin
            op_reg     <= in_op;
            len_reg    <= in_len;
            need_reg   <= ({6'b0, in_len} + GMASK) & ~GMASK;
            target_reg <= {2'b0, in_off} - {3'b0, base_reg} - HSPAN_W;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {1'b0, opay_reg, ost_reg};

    `FFA_ASSERT(a_one_item, !(m_axis_tvalid && !m_axis_tready) || !res_v || !init_reg,
        "result overwritten while pending")
    `FFA_ASSERT_NEXT(a_done_idle, state_reg == S_DONE && fin, state_reg == S_IDLE,
        "done did not return to idle")
    `FFA_ASSERT(a_ready_idle, !s_axis_tready || state_reg == S_IDLE,
        "accepted item while busy")

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for first_fit_block_allocator: a directed table, then
// random allocate/release/check and invalid-op traffic over several region
// settings, each item predicted by a local model of the block chain.
// ----------------------------------------------------------------------------
module testbench;
    import ffba_pkg::*;

    localparam int unsigned HDR_SPAN  = 24;
    localparam int unsigned GRAN      = 8;
    localparam int unsigned MAX_BYTES = 65536;
    localparam int unsigned DEPTH     = MAX_BYTES / GRAN;
    localparam int          CYCLE_CAP = 4000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // operation[1:0], length[18:2], offset[39:19]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // status[1:0], alloc_offset[22:2], zero pad
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [19:0] cfg_wdata = '0;

    first_fit_block_allocator dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct {
        logic [1:0]  status;
        logic [20:0] payload;
    } alloc_result_t;

    alloc_result_t pending_results[$];
    int unsigned   live_offsets[$];
    int            errors = 0;
    int            cycles = 0;
    bit            hold_req = 0;
    bit            steady = 0;

    // chain state mirrored from the block
    int unsigned base_q;
    int unsigned bytes_q;
    bit          head_ok;
    int unsigned blk_size [DEPTH];
    bit          blk_used [DEPTH];
    int unsigned blk_next [DEPTH];

    function automatic int unsigned slot_of(int unsigned rel);
        return (rel / GRAN < DEPTH) ? rel / GRAN : 0;
    endfunction

    function automatic void rebuild_region();
        int unsigned eff;
        eff = (bytes_q > MAX_BYTES) ? MAX_BYTES : bytes_q;
        head_ok = (eff >= HDR_SPAN);
        if (head_ok)
        begin
            blk_size[0] = eff - HDR_SPAN;
            blk_used[0] = 0;
            blk_next[0] = 0;
        end
    endfunction

    function automatic void fuse_with_next(int unsigned rel);
        int unsigned i, nx, j;
        i  = slot_of(rel);
        nx = blk_next[i];
        if (nx == 0 || nx != rel + HDR_SPAN + blk_size[i])
            return;
        j = slot_of(nx);
        if (blk_used[j])
            return;
        blk_size[i] += HDR_SPAN + blk_size[j];
        blk_next[i] = blk_next[j];
    endfunction

    function automatic void fuse_with_prev(int unsigned rel);
        int unsigned cur, i, nx;
        cur = 0;
        if (!head_ok)
            return;
        for (int n = 0; n < DEPTH; n++)
        begin
            i  = slot_of(cur);
            nx = blk_next[i];
            if (nx == rel)
            begin
                if (!blk_used[i] && cur + HDR_SPAN + blk_size[i] == rel)
                    fuse_with_next(cur);
                return;
            end
            if (nx == 0 || nx <= cur)
                return;
            cur = nx;
        end
    endfunction

    function automatic logic [1:0] find_used_block(int unsigned off, int unsigned len,
                                                   output int unsigned rel);
        int unsigned target, cur, i;
        rel = 0;
        cur = 0;
        if (off < HDR_SPAN)
            return ST_INVALID;
        if (!head_ok || off < base_q + HDR_SPAN)
            return ST_NOT_FOUND;
        target = off - base_q - HDR_SPAN;
        for (int n = 0; n < DEPTH; n++)
        begin
            i = slot_of(cur);
            if (cur == target)
            begin
                if (!blk_used[i])
                    return ST_NOT_FOUND;
                if (len > blk_size[i])
                    return ST_INVALID;
                rel = cur;
                return ST_OK;
            end
            if (cur > target || blk_next[i] == 0 || blk_next[i] <= cur)
                return ST_NOT_FOUND;
            cur = blk_next[i];
        end
        return ST_NOT_FOUND;
    endfunction

    function automatic logic [1:0] first_fit(int unsigned len, output int unsigned pay);
        int unsigned need, cur, i, rest, nrel, j;
        need = ((len + GRAN - 1) / GRAN) * GRAN;
        cur  = 0;
        pay  = 0;
        if (!head_ok)
            return ST_NO_SPACE;
        for (int n = 0; n < DEPTH; n++)
        begin
            i = slot_of(cur);
            if (!blk_used[i] && blk_size[i] >= need)
            begin
                rest = blk_size[i] - need;
                if (rest >= HDR_SPAN + GRAN)
                begin
                    nrel = cur + HDR_SPAN + need;
                    j = slot_of(nrel);
                    blk_used[j] = 0;
                    blk_size[j] = rest - HDR_SPAN;
                    blk_next[j] = blk_next[i];
                    blk_size[i] = need;
                    blk_next[i] = nrel;
                end
                blk_used[i] = 1;
                pay = (base_q + cur + HDR_SPAN) & 21'h1FFFFF;
                return ST_OK;
            end
            if (blk_next[i] == 0 || blk_next[i] <= cur)
                break;
            cur = blk_next[i];
        end
        return ST_NO_SPACE;
    endfunction

    function automatic alloc_result_t predict_result(logic [1:0] op, int unsigned len,
                                                     int unsigned off);
        alloc_result_t r;
        int unsigned   rel, pay;
        pay = 0;
        case (op)
            OP_ALLOC:   r.status = first_fit(len, pay);
            OP_RELEASE:
            begin
                r.status = find_used_block(off, 0, rel);
                if (r.status == ST_OK)
                begin
                    blk_used[slot_of(rel)] = 0;
                    fuse_with_next(rel);
                    fuse_with_prev(rel);
                end
            end
            OP_CHECK:   r.status = head_ok ? find_used_block(off, len, rel) : ST_NO_SPACE;
            default:    r.status = ST_INVALID;
        endcase
        r.payload = (r.status == ST_OK) ? pay[20:0] : '0;
        return r;
    endfunction

    // sends one item, returns its predicted result; gap = idle cycles after it
    task automatic send_item(input logic [1:0] op, input int unsigned len,
                             input int unsigned off, input int gap,
                             output alloc_result_t r);
        bit hs;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {off[20:0], len[16:0], op};
        do
        begin
            @(negedge clk);
            hs = s_axis_tready;
            @(posedge clk);
        end
        while (!hs);
        r = predict_result(op, len, off);
        pending_results.push_back(r);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // waits for every result and for the block to go idle (merges run on
    // after a release result has left)
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0 || !s_axis_tready);
        @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[19:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_REGION_BASE)
            base_q = value & 20'hFFFFF;
        else
            bytes_q = value & 17'h1FFFF;
        rebuild_region();
        live_offsets.delete();
    endtask

    function automatic int pick_gap();
        int k;
        if (steady)
            return 0;
        k = $urandom_range(0, 19);
        if (k < 13)
            return 0;
        if (k < 19)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result checker; sampled mid-cycle, the handshake completes at the next edge
    always @(negedge clk)
    begin
        alloc_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[22:2] !== e.payload)
                begin
                    $error("alloc_offset: expected %h, got %h", e.payload,
                           m_axis_tdata[22:2]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int k;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            else if (steady)
                m_axis_tready <= 1'b1;
            else
            begin
                k = $urandom_range(0, 19);
                if (k < 12)
                    m_axis_tready <= 1'b1;
                else if (k < 19)
                    m_axis_tready <= 1'b0;
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    typedef struct {
        bit          is_cfg;
        logic [1:0]  op;      // register index on config rows
        int unsigned len;
        int unsigned off;     // value on config rows
        bit          known;
        logic [1:0]  status;
        int unsigned payload;
    } stim_row_t;

    stim_row_t directed [] = '{
        '{0, OP_ALLOC,   0,      0,        1, ST_OK,        24},
        '{0, OP_ALLOC,   1,      0,        0, ST_OK,        0},
        '{0, OP_ALLOC,   65536,  0,        1, ST_NO_SPACE,  0},
        '{0, OP_RELEASE, 0,      8,        1, ST_INVALID,   0},
        '{0, OP_CHECK,   0,      8,        1, ST_INVALID,   0},
        '{0, OP_RELEASE, 0,      25,       1, ST_NOT_FOUND, 0},
        '{0, OP_CHECK,   0,      24,       1, ST_OK,        0},
        '{0, OP_CHECK,   9,      56,       0, ST_OK,        0},
        '{0, 2'd3,       131071, 2097151,  1, ST_INVALID,   0},
        '{0, OP_RELEASE, 0,      24,       1, ST_OK,        0},
        '{0, OP_RELEASE, 0,      24,       1, ST_NOT_FOUND, 0},
        '{0, OP_CHECK,   0,      24,       1, ST_NOT_FOUND, 0},
        '{0, OP_RELEASE, 0,      48,       0, ST_OK,        0},
        '{0, OP_ALLOC,   65512,  0,        1, ST_OK,        24},
        '{0, OP_ALLOC,   1,      0,        1, ST_NO_SPACE,  0},
        '{0, OP_CHECK,   131071, 2097151,  1, ST_NOT_FOUND, 0},
        '{0, OP_RELEASE, 0,      24,       1, ST_OK,        0},
        // region smaller than a header
        '{1, CFG_REGION_BYTES, 0, 16,      0, ST_OK,        0},
        '{0, OP_ALLOC,   0,      0,        1, ST_NO_SPACE,  0},
        '{0, OP_RELEASE, 0,      24,       1, ST_NOT_FOUND, 0},
        '{0, OP_CHECK,   0,      8,        1, ST_NO_SPACE,  0},
        // exactly one header, zero payload
        '{1, CFG_REGION_BYTES, 0, 24,      0, ST_OK,        0},
        '{0, OP_ALLOC,   0,      0,        1, ST_OK,        24},
        '{0, OP_ALLOC,   0,      0,        1, ST_NO_SPACE,  0},
        '{0, OP_CHECK,   1,      24,       1, ST_INVALID,   0}
    };

    initial
    begin
        alloc_result_t r;
        int unsigned   len, off, idx;
        int            k;
        logic [1:0]    op;
        int unsigned   bases [8] = '{0, 0, 20'hFFFFF, 0, 20'h12345, 20'h80000, 0, 0};
        int unsigned   sizes [8] = '{1000, 131071, 65536, 4096, 520, 300, 65536, 2048};

        base_q  = 0;
        bytes_q = MAX_BYTES;
        rebuild_region();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            if (directed[n].is_cfg)
                write_reg(directed[n].op[0], directed[n].off);
            else
            begin
                send_item(directed[n].op, directed[n].len, directed[n].off, pick_gap(), r);
                if (directed[n].known && r.status !== directed[n].status)
                begin
                    $error("row %0d status: expected %0d, predicted %0d", n,
                           directed[n].status, r.status);
                    errors++;
                end
                if (directed[n].known && r.payload !== directed[n].payload[20:0])
                begin
                    $error("row %0d alloc_offset: expected %h, predicted %h", n,
                           directed[n].payload[20:0], r.payload);
                    errors++;
                end
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_REGION_BASE, bases[ph]);
            write_reg(CFG_REGION_BYTES, sizes[ph]);
            steady = (ph == 6);
            for (int n = 0; n < 125; n++)
            begin
                if (ph == 1 && n == 10)
                    hold_req = 1;
                if (ph == 3 && n == 60)
                    drain();
                k = $urandom_range(0, 99);
                if (live_offsets.size() >= 40 && k < 45)
                    k = 50;
                if (live_offsets.size() == 0 && k >= 45 && k < 92)
                    k = 0;
                if (k < 45)
                begin
                    op  = OP_ALLOC;
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65536)
                                                      : $urandom_range(0, 256);
                    off = $urandom_range(0, 2097151);
                end
                else if (k < 92)
                begin
                    idx = $urandom_range(0, live_offsets.size() - 1);
                    off = live_offsets[idx];
                    op  = (k < 80) ? OP_RELEASE : OP_CHECK;
                    len = $urandom_range(0, 300);
                end
                else
                begin
                    op  = 2'($urandom_range(0, 3));
                    len = $urandom_range(0, 131071);
                    off = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2097151)
                                                      : base_q + $urandom_range(0, 4096);
                end
                send_item(op, len, off, pick_gap(), r);
                if (op == OP_ALLOC && r.status == ST_OK)
                    live_offsets.push_back(32'(r.payload));
                else if (op == OP_RELEASE && r.status == ST_OK)
                begin
                    foreach (live_offsets[m])
                        if (live_offsets[m] == off)
                        begin
                            live_offsets.delete(m);
                            break;
                        end
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ffba_pkg.sv
hdl/ffba_hdr_mem.sv
hdl/first_fit_block_allocator.sv
tb/sv/testbench.sv
